### rtl/core/assert_macros.svh
// ---------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms for the RTL, clocked on aclk and
// disabled while aresetn is low.
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// check prop at every edge outside reset
`define RCLW_ASSERT(label, prop, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (prop)) else $error(msg);

// check that trig implies prop at the same edge
`define RCLW_ASSERT_IMP(label, trig, prop, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (trig) |-> (prop)) \
        else $error(msg);

`endif

### rtl/core/rclw_pkg.sv
// ---------------------------------------------------------------------------
// rclw_pkg
// Types and constants of the remote-control frame receiver and link watch.
// ---------------------------------------------------------------------------
package rclw_pkg;

    localparam int FRAME_BYTES = 18;
    localparam int BCNT_W      = $clog2(FRAME_BYTES + 1);
    localparam int IDX_W       = $clog2(FRAME_BYTES);
    localparam int TICK_W      = 10;
    localparam int CFG_IDX_W   = 8;
    localparam int CFG_DATA_W  = 16;

    localparam logic [TICK_W-1:0] TICK_MAX         = '1;
    localparam logic [TICK_W-1:0] LOST_TIMEOUT_RST = 10'd4;
    localparam logic [TICK_W-1:0] CONN_TIMEOUT_RST = 10'd100;
    localparam logic [10:0]       CH_CENTER        = 11'd1024;

    localparam logic ACT_BYTE = 1'b0;
    localparam logic ACT_TICK = 1'b1;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_LOST_TIMEOUT = 8'd0,
        REG_CONN_TIMEOUT = 8'd1
    } cfg_reg_t;

    typedef logic [FRAME_BYTES-1:0][7:0] frame_t;

    typedef struct packed {
        logic       action;
        logic [7:0] rx_byte;
    } in_item_t;

    typedef struct packed {
        logic [10:0]        channel_zero;
        logic [10:0]        channel_one;
        logic [10:0]        channel_two;
        logic [10:0]        channel_three;
        logic [3:0]         switches;
        logic signed [15:0] mouse_x;
        logic signed [15:0] mouse_y;
        logic signed [15:0] mouse_z;
        logic [7:0]         mouse_left;
        logic [7:0]         mouse_right;
        logic [15:0]        key_bitmap;
    } fields_t;

    typedef struct packed {
        logic               link_connected;
        logic [10:0]        channel_zero;
        logic [10:0]        channel_one;
        logic [10:0]        channel_two;
        logic [10:0]        channel_three;
        logic [3:0]         switches;
        logic signed [15:0] mouse_x;
        logic signed [15:0] mouse_y;
        logic signed [15:0] mouse_z;
        logic [7:0]         mouse_left;
        logic [7:0]         mouse_right;
        logic [15:0]        key_bitmap;
    } out_item_t;

    localparam fields_t FIELDS_CLEAR = '{
        channel_zero:  CH_CENTER,
        channel_one:   CH_CENTER,
        channel_two:   CH_CENTER,
        channel_three: CH_CENTER,
        switches:      4'd0,
        mouse_x:       16'sd0,
        mouse_y:       16'sd0,
        mouse_z:       16'sd0,
        mouse_left:    8'd0,
        mouse_right:   8'd0,
        key_bitmap:    16'd0
    };

endpackage

### rtl/core/rclw_decode.sv
// ---------------------------------------------------------------------------
// rclw_decode
// Unpacks one received frame into stick channels, switches, mouse and keys.
// ---------------------------------------------------------------------------
module rclw_decode
    import rclw_pkg::*;
(
    input  frame_t  frame,
    output fields_t fields
);

    always_comb begin
        fields.channel_zero  = {frame[1][2:0], frame[0]};
        fields.channel_one   = {frame[2][5:0], frame[1][7:3]};
        fields.channel_two   = {frame[4][0], frame[3], frame[2][7:6]};
        fields.channel_three = {frame[5][3:0], frame[4][7:1]};
        fields.switches      = frame[5][7:4];
        fields.mouse_x       = $signed({frame[7], frame[6]});
        fields.mouse_y       = $signed({frame[9], frame[8]});
        fields.mouse_z       = $signed({frame[11], frame[10]});
        fields.mouse_left    = frame[12];
        fields.mouse_right   = frame[13];
        fields.key_bitmap    = {frame[15], frame[14]};
    end

endmodule

### rtl/core/rc_frame_receiver_link_watch.sv
// ---------------------------------------------------------------------------
// rc_frame_receiver_link_watch
// Remote-control frame receiver with link timeout watch.
// ---------------------------------------------------------------------------
// Input channel (s_valid/s_ready/s_item): each item is a received UART byte
// or a one-millisecond tick. Bytes fill an 18-byte frame store; the first completed
// frame only arms, later ones bring a lost link up or, on a connected link, update
// the decoded sticks, switches, mouse and key fields. Ticks count toward the
// timeout of the current link state; on timeout the link drops and the fields clear.
// Result channel (m_valid/m_ready/m_item): one item per acted-on frame or
// timeout, carrying the link state and all decoded fields.
// Config channel (cfg_valid/cfg_ready/cfg_index/cfg_data): index 0 sets the
// lost timeout, index 1 the connected timeout, in ticks; ready outside reset.
// A result is registered in out_reg, or in skid_reg while out_reg still waits.
// Throughput: one item per cycle; the state update is a single registered
// step. A two-entry output buffer (result register plus skid) lets input
// flow on while a result waits; s_ready drops only when both are full.
// Reset: link lost, frame store empty, channels 1024, other fields zero,
// timeouts 4 and 100 ticks; no clearing pass.
// ---------------------------------------------------------------------------
module rc_frame_receiver_link_watch
    import rclw_pkg::*;
(
    input  logic                  aclk,
    input  logic                  aresetn,

    input  logic                  s_valid,
    output logic                  s_ready,
    input  in_item_t              s_item,

    output logic                  m_valid,
    input  logic                  m_ready,
    output out_item_t             m_item,

    input  logic                  cfg_valid,
    output logic                  cfg_ready,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data
);

`include "assert_macros.svh"

    logic [TICK_W-1:0] lost_timeout_reg;
    logic [TICK_W-1:0] conn_timeout_reg;

    logic              link_up_reg,    link_up_next;
    logic              seen_first_reg, seen_first_next;
    logic [BCNT_W-1:0] byte_count_reg, byte_count_next;
    logic [TICK_W-1:0] tick_count_reg, tick_count_next;
    fields_t           fields_reg,     fields_next;
    frame_t            store_reg;

    out_item_t         out_reg;
    logic              out_valid_reg;
    out_item_t         skid_reg;
    logic              skid_valid_reg;

    logic              accept;
    logic              store_wr;
    logic              push;
    logic [TICK_W-1:0] tick_inc;
    logic [TICK_W-1:0] limit;
    frame_t            frame;
    fields_t           decoded;
    out_item_t         result;
    logic              out_take;

    assign cfg_ready = aresetn;
    assign s_ready   = aresetn && !skid_valid_reg;
    assign accept    = s_valid && s_ready;
    assign m_valid   = out_valid_reg;
    assign m_item    = out_reg;
    assign out_take  = out_valid_reg && m_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            lost_timeout_reg <= LOST_TIMEOUT_RST;
            conn_timeout_reg <= CONN_TIMEOUT_RST;
        end else if (cfg_valid && cfg_ready) begin
            unique case (cfg_index)
                REG_LOST_TIMEOUT: lost_timeout_reg <= cfg_data[TICK_W-1:0];
                REG_CONN_TIMEOUT: conn_timeout_reg <= cfg_data[TICK_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        for (int i = 0; i < FRAME_BYTES; i++) begin
            frame[i] = (byte_count_reg == BCNT_W'(i)) ? s_item.rx_byte : store_reg[i];
        end
    end

    rclw_decode u_decode (
        .frame  (frame),
        .fields (decoded)
    );

    assign store_wr = accept && (s_item.action == ACT_BYTE)
                   && (byte_count_reg < BCNT_W'(FRAME_BYTES));

    always_comb begin
        link_up_next    = link_up_reg;
        seen_first_next = seen_first_reg;
        byte_count_next = byte_count_reg;
        tick_count_next = tick_count_reg;
        fields_next     = fields_reg;
        push            = 1'b0;

        tick_inc = (tick_count_reg != TICK_MAX) ? tick_count_reg + 1'b1 : tick_count_reg;
        limit    = link_up_reg ? conn_timeout_reg : lost_timeout_reg;
        if (limit == '0) begin
            limit = TICK_W'(1);
        end

        if (accept) begin
            if (s_item.action == ACT_BYTE) begin
                if (store_wr) begin
                    byte_count_next = byte_count_reg + 1'b1;
                    if (byte_count_reg == BCNT_W'(FRAME_BYTES - 1)) begin
                        if (!seen_first_reg) begin
                            seen_first_next = 1'b1;
                        end else begin
                            if (!link_up_reg) begin
                                link_up_next = 1'b1;
                            end else begin
                                fields_next = decoded;
                            end
                            byte_count_next = '0;
                            tick_count_next = '0;
                            push            = 1'b1;
                        end
                    end
                end
            end else begin
                tick_count_next = tick_inc;
                if (tick_inc >= limit) begin
                    link_up_next    = 1'b0;
                    fields_next     = FIELDS_CLEAR;
                    byte_count_next = '0;
                    tick_count_next = '0;
                    push            = 1'b1;
                end
            end
        end

        result.link_connected = link_up_next;
        result.channel_zero   = fields_next.channel_zero;
        result.channel_one    = fields_next.channel_one;
        result.channel_two    = fields_next.channel_two;
        result.channel_three  = fields_next.channel_three;
        result.switches       = fields_next.switches;
        result.mouse_x        = fields_next.mouse_x;
        result.mouse_y        = fields_next.mouse_y;
        result.mouse_z        = fields_next.mouse_z;
        result.mouse_left     = fields_next.mouse_left;
        result.mouse_right    = fields_next.mouse_right;
        result.key_bitmap     = fields_next.key_bitmap;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            link_up_reg    <= 1'b0;
            seen_first_reg <= 1'b0;
            byte_count_reg <= '0;
            tick_count_reg <= '0;
            fields_reg     <= FIELDS_CLEAR;
        end else begin
            link_up_reg    <= link_up_next;
            seen_first_reg <= seen_first_next;
            byte_count_reg <= byte_count_next;
            tick_count_reg <= tick_count_next;
            fields_reg     <= fields_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (store_wr) begin
            store_reg[byte_count_reg[IDX_W-1:0]] <= s_item.rx_byte;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end else if (skid_valid_reg) begin
            if (out_take) begin
                out_reg        <= skid_reg;
                skid_valid_reg <= 1'b0;
            end
        end else if (push) begin
            if (!out_valid_reg || out_take) begin
                out_reg       <= result;
                out_valid_reg <= 1'b1;
            end else begin
                skid_reg       <= result;
                skid_valid_reg <= 1'b1;
            end
        end else if (out_take) begin
            out_valid_reg <= 1'b0;
        end
    end

    `RCLW_ASSERT_IMP(a_skid_behind_out, skid_valid_reg, out_valid_reg, "skid without output item")
    `RCLW_ASSERT(a_count_in_range, byte_count_reg <= BCNT_W'(FRAME_BYTES), "byte count too high")
    `RCLW_ASSERT_IMP(a_lost_centered, !link_up_reg, fields_reg.channel_zero == CH_CENTER, "off center")
    `RCLW_ASSERT_IMP(a_up_after_first, link_up_reg, seen_first_reg, "link up before first frame")

endmodule

### tb/rc_frame_receiver_link_watch_tb.sv
// ----------------------------------------------------------------------------
// rc_frame_receiver_link_watch_tb
// Drives received bytes and millisecond ticks into the frame receiver. A
// built-in predictor tracks the frame store, tick counter and link state,
// and each result is checked field by field. Timeout settings change between
// phases while the block is idle. Idle and stall patterns vary by phase.
// ----------------------------------------------------------------------------
module rc_frame_receiver_link_watch_tb
    import rclw_pkg::*;
();

    timeunit 1ns;
    timeprecision 1ps;

    localparam int LONG_STALL = 300;
    localparam logic [CFG_IDX_W-1:0] REG_SPARE     = 8'd2;
    localparam logic [CFG_IDX_W-1:0] REG_INDEX_TOP = 8'hFF;

    typedef struct packed {
        logic [CFG_IDX_W-1:0]  idx;
        logic [CFG_DATA_W-1:0] data;
    } cfg_write_t;

    logic                  aclk      = 1'b0;
    logic                  aresetn   = 1'b0;
    logic                  s_valid   = 1'b0;
    logic                  s_ready;
    in_item_t              s_item    = '0;
    logic                  m_valid;
    logic                  m_ready   = 1'b0;
    out_item_t             m_item;
    logic                  cfg_valid = 1'b0;
    logic                  cfg_ready;
    logic [CFG_IDX_W-1:0]  cfg_index = '0;
    logic [CFG_DATA_W-1:0] cfg_data  = '0;

    in_item_t   link_input_q[$];
    cfg_write_t timeout_write_q[$];
    out_item_t  pending_reports[$];

    int items_queued   = 0;
    int items_accepted = 0;
    int writes_queued  = 0;
    int writes_done    = 0;
    int mismatch_count = 0;
    int send_idle_pct  = 0;
    int recv_stall_pct = 0;
    logic stall_arm  = 1'b0;
    logic stall_seen = 1'b0;
    int   stall_left = 0;

    logic              exp_link_up;
    logic              exp_seen_first;
    int                exp_byte_count;
    logic [7:0]        exp_frame [0:FRAME_BYTES-1];
    logic [TICK_W-1:0] exp_tick_count;
    logic [TICK_W-1:0] lost_limit;
    logic [TICK_W-1:0] conn_limit;
    fields_t           exp_fields;

    rc_frame_receiver_link_watch dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_item    (s_item),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_item    (m_item),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always #5 aclk = ~aclk;

    function automatic fields_t idle_fields();
        fields_t f;
        f.channel_zero  = CH_CENTER;
        f.channel_one   = CH_CENTER;
        f.channel_two   = CH_CENTER;
        f.channel_three = CH_CENTER;
        f.switches      = '0;
        f.mouse_x       = '0;
        f.mouse_y       = '0;
        f.mouse_z       = '0;
        f.mouse_left    = '0;
        f.mouse_right   = '0;
        f.key_bitmap    = '0;
        return f;
    endfunction

    function automatic fields_t unpack_frame();
        fields_t f;
        f.channel_zero  = {exp_frame[1][2:0], exp_frame[0]};
        f.channel_one   = {exp_frame[2][5:0], exp_frame[1][7:3]};
        f.channel_two   = {exp_frame[4][0], exp_frame[3], exp_frame[2][7:6]};
        f.channel_three = {exp_frame[5][3:0], exp_frame[4][7:1]};
        f.switches      = exp_frame[5][7:4];
        f.mouse_x       = {exp_frame[7], exp_frame[6]};
        f.mouse_y       = {exp_frame[9], exp_frame[8]};
        f.mouse_z       = {exp_frame[11], exp_frame[10]};
        f.mouse_left    = exp_frame[12];
        f.mouse_right   = exp_frame[13];
        f.key_bitmap    = {exp_frame[15], exp_frame[14]};
        return f;
    endfunction

    function automatic void reset_link_model();
        exp_link_up    = 1'b0;
        exp_seen_first = 1'b0;
        exp_byte_count = 0;
        exp_tick_count = '0;
        lost_limit     = LOST_TIMEOUT_RST;
        conn_limit     = CONN_TIMEOUT_RST;
        exp_fields     = idle_fields();
    endfunction

    function automatic void predict_link_report(input in_item_t it);
        logic [TICK_W-1:0] limit;
        if (it.action == ACT_BYTE) begin
            if (exp_byte_count >= FRAME_BYTES) return;
            exp_frame[exp_byte_count] = it.rx_byte;
            exp_byte_count++;
            if (exp_byte_count < FRAME_BYTES) return;
            if (!exp_seen_first) begin
                exp_seen_first = 1'b1;
                return;
            end
            if (!exp_link_up) exp_link_up = 1'b1;
            else exp_fields = unpack_frame();
        end else begin
            limit = exp_link_up ? conn_limit : lost_limit;
            if (limit == '0) limit = TICK_W'(1);
            if (exp_tick_count < TICK_MAX) exp_tick_count++;
            if (exp_tick_count < limit) return;
            exp_link_up = 1'b0;
            exp_fields  = idle_fields();
        end
        exp_byte_count = 0;
        exp_tick_count = '0;
        pending_reports.push_back(out_item_t'({exp_link_up, exp_fields}));
    endfunction

    function automatic void check_field(string name, longint want, longint got);
        if (want != got) begin
            $error("%s expected %0d actual %0d", name, want, got);
            mismatch_count++;
        end
    endfunction

    function automatic void compare_report(out_item_t want, out_item_t got);
        check_field("link_connected", want.link_connected, got.link_connected);
        check_field("channel_zero", want.channel_zero, got.channel_zero);
        check_field("channel_one", want.channel_one, got.channel_one);
        check_field("channel_two", want.channel_two, got.channel_two);
        check_field("channel_three", want.channel_three, got.channel_three);
        check_field("switches", want.switches, got.switches);
        check_field("mouse_x", want.mouse_x, got.mouse_x);
        check_field("mouse_y", want.mouse_y, got.mouse_y);
        check_field("mouse_z", want.mouse_z, got.mouse_z);
        check_field("mouse_left", want.mouse_left, got.mouse_left);
        check_field("mouse_right", want.mouse_right, got.mouse_right);
        check_field("key_bitmap", want.key_bitmap, got.key_bitmap);
    endfunction

    function automatic void push_input(logic act, logic [7:0] b);
        in_item_t it;
        it.action  = act;
        it.rx_byte = b;
        link_input_q.push_back(it);
        items_queued++;
    endfunction

    function automatic logic [7:0] pick_byte();
        int r;
        r = $urandom_range(9, 0);
        if (r == 0) return 8'h00;
        if (r == 1) return 8'hFF;
        return 8'($urandom);
    endfunction

    function automatic void push_tick();
        push_input(ACT_TICK, 8'($urandom));
    endfunction

    // mostly whole frames, some tick bursts, cut-off frames and stray bytes
    function automatic void add_traffic(int n_items);
        int made;
        int pick;
        int len;
        made = 0;
        while (made < n_items) begin
            pick = $urandom_range(99, 0);
            if (pick < 60) begin
                for (int i = 0; i < FRAME_BYTES; i++) begin
                    if ($urandom_range(19, 0) == 0) begin
                        push_tick();
                        made++;
                    end
                    push_input(ACT_BYTE, pick_byte());
                    made++;
                end
            end else if (pick < 78) begin
                len = $urandom_range(12, 1);
                repeat (len) push_tick();
                made += len;
            end else if (pick < 90) begin
                len = $urandom_range(FRAME_BYTES - 1, 1);
                repeat (len) push_input(ACT_BYTE, pick_byte());
                made += len;
            end else begin
                push_input(ACT_BYTE, 8'($urandom));
                made++;
            end
        end
    endfunction

    function automatic void write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
        timeout_write_q.push_back('{idx: idx, data: data});
        writes_queued++;
    endfunction

    task automatic wait_idle();
        int guard;
        while (items_accepted != items_queued) @(posedge aclk);
        guard = 0;
        while (pending_reports.size() != 0 && guard < 2000) begin
            @(posedge aclk);
            guard++;
        end
        repeat (4) @(posedge aclk);
    endtask

    task automatic settle_writes();
        while (writes_done != writes_queued) @(posedge aclk);
        repeat (2) @(posedge aclk);
    endtask

    // input driver
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_valid <= 1'b0;
        end else begin
            if (s_valid && s_ready) begin
                predict_link_report(s_item);
                items_accepted++;
            end
            if (!s_valid || s_ready) begin
                if (link_input_q.size() != 0 && $urandom_range(99, 0) >= send_idle_pct) begin
                    s_item  <= link_input_q.pop_front();
                    s_valid <= 1'b1;
                end else begin
                    s_valid <= 1'b0;
                end
            end
        end
    end

    // timeout register writes
    always @(posedge aclk) begin
        if (!aresetn) begin
            cfg_valid <= 1'b0;
        end else begin
            if (cfg_valid && cfg_ready) begin
                if (cfg_index == REG_LOST_TIMEOUT) lost_limit = cfg_data[TICK_W-1:0];
                else if (cfg_index == REG_CONN_TIMEOUT) conn_limit = cfg_data[TICK_W-1:0];
                writes_done++;
            end
            if (!cfg_valid || cfg_ready) begin
                if (timeout_write_q.size() != 0) begin
                    {cfg_index, cfg_data} <= timeout_write_q.pop_front();
                    cfg_valid <= 1'b1;
                end else begin
                    cfg_valid <= 1'b0;
                end
            end
        end
    end

    // result side backpressure
    always @(posedge aclk) begin
        if (stall_seen != stall_arm) begin
            stall_seen <= stall_arm;
            stall_left <= LONG_STALL;
            m_ready    <= 1'b0;
        end else if (stall_left > 0) begin
            stall_left <= stall_left - 1;
            m_ready    <= 1'b0;
        end else begin
            m_ready <= ($urandom_range(99, 0) >= recv_stall_pct);
        end
    end

    // result monitor
    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready) begin
            if (pending_reports.size() == 0) begin
                $error("unexpected item: %p", m_item);
                mismatch_count++;
            end else begin
                compare_report(pending_reports.pop_front(), m_item);
            end
        end
    end

    initial begin
        reset_link_model();
        repeat (12) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // arm on the first frame, overflow the full store, then time out
        for (int i = 0; i < FRAME_BYTES; i++) push_input(ACT_BYTE, i[0] ? 8'hFF : 8'h00);
        push_input(ACT_BYTE, 8'h5A);
        push_input(ACT_BYTE, 8'hA5);
        repeat (4) push_tick();
        wait_idle();

        write_reg(REG_LOST_TIMEOUT, 16'd1);
        write_reg(REG_CONN_TIMEOUT, 16'd3);
        settle_writes();
        send_idle_pct = 62;
        add_traffic(200);
        wait_idle();

        write_reg(REG_LOST_TIMEOUT, 16'h03FF);
        write_reg(REG_CONN_TIMEOUT, 16'hFFFF);
        settle_writes();
        send_idle_pct  = 0;
        recv_stall_pct = 62;
        add_traffic(200);
        wait_idle();

        write_reg(REG_LOST_TIMEOUT, 16'd0);
        write_reg(REG_CONN_TIMEOUT, 16'hFC07);
        write_reg(REG_SPARE, 16'h5555);
        write_reg(REG_INDEX_TOP, 16'hAAAA);
        settle_writes();
        send_idle_pct  = 6;
        recv_stall_pct = 6;
        add_traffic(250);
        wait_idle();

        write_reg(REG_LOST_TIMEOUT, 16'd1);
        write_reg(REG_CONN_TIMEOUT, 16'd5);
        settle_writes();
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        @(posedge aclk);
        stall_arm <= ~stall_arm;
        repeat (60) push_tick();
        add_traffic(40);
        wait_idle();
        add_traffic(210);
        wait_idle();

        write_reg(REG_LOST_TIMEOUT, 16'd4);
        write_reg(REG_CONN_TIMEOUT, 16'($urandom_range(40, 2)));
        settle_writes();
        recv_stall_pct = 62;
        add_traffic(150);
        wait_idle();

        if (pending_reports.size() != 0) begin
            $error("%0d expected results never arrived", pending_reports.size());
            mismatch_count++;
        end
        if (mismatch_count == 0) begin
            $display("No mismatches found");
        end else begin
            $display("Mismatches found");
        end
        $finish;
    end

    initial begin
        #2ms;
        $display("Mismatches found");
        $finish;
    end

endmodule
